[sv/nts_pkg.sv]
// ----------------------------------------------------------------------------
// nts_pkg
// Types and constants shared by the nearest timestamp frame table.
// ----------------------------------------------------------------------------
package nts_pkg;

  localparam int DEPTH   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int STAMP_W = 52;
  localparam int CAP_W   = 6;
  localparam int SLOT_W  = 5;
  localparam int FILL_W  = 6;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [STAMP_W-1:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              found;
    logic              exact;
    logic              evicted;
    logic [FILL_W-1:0] fill;
  } out_item_t;

  // per-cell control
  typedef struct packed {
    logic shift;
    logic clr;
    logic wr;
  } cell_ctl_t;

  // scan unit control
  typedef struct packed {
    logic             start;
    logic             step;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  // what one pass over the ring found
  typedef struct packed {
    logic               ex_have;
    logic [IDX_W-1:0]   ex_idx;
    logic               free_have;
    logic [IDX_W-1:0]   free_idx;
    logic               min_have;
    logic [IDX_W-1:0]   min_idx;
    logic               lo_have;
    logic [IDX_W-1:0]   lo_idx;
    logic [STAMP_W-1:0] lo_stamp;
    logic               hi_have;
    logic [IDX_W-1:0]   hi_idx;
    logic [STAMP_W-1:0] hi_stamp;
  } scan_res_t;

endpackage

[sv/nts_cell.sv]
// ----------------------------------------------------------------------------
// nts_cell
// One table entry: a timestamp and a valid bit, shifted around the ring.
// ----------------------------------------------------------------------------
module nts_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nts_pkg::cell_ctl_t          ctl_i,
  input  logic [nts_pkg::STAMP_W-1:0] nxt_stamp_i,
  input  logic                        nxt_valid_i,
  input  logic [nts_pkg::STAMP_W-1:0] wr_stamp_i,
  output logic [nts_pkg::STAMP_W-1:0] stamp_o,
  output logic                        valid_o
);

  logic [nts_pkg::STAMP_W-1:0] stamp_q;
  logic                        valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.clr) begin
      valid_q <= 1'b0;
    end else if (ctl_i.wr) begin
      valid_q <= 1'b1;
    end else if (ctl_i.shift) begin
      valid_q <= nxt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      stamp_q <= wr_stamp_i;
    end else if (ctl_i.shift) begin
      stamp_q <= nxt_stamp_i;
    end
  end

  assign stamp_o = stamp_q;
  assign valid_o = valid_q;

endmodule

[sv/nts_scan.sv]
// ----------------------------------------------------------------------------
// nts_scan
// Watches the head cell of the ring and tracks exact match, first free slot,
// oldest entry and the nearest neighbors below and above the key.
// ----------------------------------------------------------------------------
module nts_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nts_pkg::scan_ctl_t          ctl_i,
  input  logic [nts_pkg::STAMP_W-1:0] key_i,
  input  logic [nts_pkg::STAMP_W-1:0] head_stamp_i,
  input  logic                        head_valid_i,
  output nts_pkg::scan_res_t          res_o
);

  nts_pkg::scan_res_t          res_q, res_d;
  logic [nts_pkg::STAMP_W-1:0] min_stamp_q, min_stamp_d;

  always_comb begin
    res_d       = res_q;
    min_stamp_d = min_stamp_q;
    if (ctl_i.start) begin
      res_d.ex_have   = 1'b0;
      res_d.free_have = 1'b0;
      res_d.min_have  = 1'b0;
      res_d.lo_have   = 1'b0;
      res_d.hi_have   = 1'b0;
    end else if (ctl_i.step) begin
      if (head_valid_i) begin
        if (head_stamp_i == key_i && !res_q.ex_have) begin
          res_d.ex_have = 1'b1;
          res_d.ex_idx  = ctl_i.idx;
        end
        if (!res_q.min_have || head_stamp_i < min_stamp_q) begin
          res_d.min_have = 1'b1;
          res_d.min_idx  = ctl_i.idx;
          min_stamp_d    = head_stamp_i;
        end
        if (head_stamp_i < key_i) begin
          if (!res_q.lo_have || head_stamp_i > res_q.lo_stamp) begin
            res_d.lo_have  = 1'b1;
            res_d.lo_idx   = ctl_i.idx;
            res_d.lo_stamp = head_stamp_i;
          end
        end else if (head_stamp_i > key_i) begin
          if (!res_q.hi_have || head_stamp_i < res_q.hi_stamp) begin
            res_d.hi_have  = 1'b1;
            res_d.hi_idx   = ctl_i.idx;
            res_d.hi_stamp = head_stamp_i;
          end
        end
      end else if (!res_q.free_have) begin
        res_d.free_have = 1'b1;
        res_d.free_idx  = ctl_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q       <= '0;
      min_stamp_q <= '0;
    end else begin
      res_q       <= res_d;
      min_stamp_q <= min_stamp_d;
    end
  end

  assign res_o = res_q;

endmodule

[sv/nearest_timestamp_frame_table_core.sv]
// ----------------------------------------------------------------------------
// nearest_timestamp_frame_table_core
// Timestamp keyed frame slot table with oldest-first eviction and
// nearest-neighbor lookup, built as a rotating ring of entry cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_item_i  (kind, stamp)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (slot..fill)
//  cfg     | input     | cfg_we_i                  | cfg_wdata_i (capacity)
//
// Insert and lookup are accepted in IDLE, then rotate the entries once past the
// head cell in SCAN, and decide and write back in FINISH. Clear and the unused
// kind go from IDLE straight to FINISH. One item is in flight at a time.
// Reset empties the table at once and sets capacity to 30.
// A stalled output holds the result; the next item may already be accepted
// and waits in its final cycle until the output register is free.
// ----------------------------------------------------------------------------
module nearest_timestamp_frame_table_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [nts_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  nts_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output nts_pkg::out_item_t        out_item_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e                       state_q;
  logic [nts_pkg::STAMP_W-1:0]  key_q;
  logic [1:0]                   kind_q;
  logic [nts_pkg::IDX_W-1:0]    idx_q;
  logic [nts_pkg::CNT_W-1:0]    count_q, count_d;
  logic [nts_pkg::CAP_W-1:0]    cap_q;
  nts_pkg::out_item_t           out_q, out_d;
  logic                         out_valid_q;

  logic                         accept;
  logic                         finish;
  logic                         out_free;

  logic [nts_pkg::STAMP_W-1:0]  cell_stamp [nts_pkg::DEPTH];
  logic                         cell_valid [nts_pkg::DEPTH];
  logic                         wr_en;
  logic [nts_pkg::IDX_W-1:0]    wr_idx;
  logic                         clr_all;

  nts_pkg::scan_ctl_t           scan_ctl;
  nts_pkg::scan_res_t           scan_res;

  logic [nts_pkg::CMP_W-1:0]    cap_ext;
  logic [nts_pkg::CMP_W-1:0]    eff_cap;
  logic                         full;
  logic [nts_pkg::STAMP_W-1:0]  dist_lo, dist_hi;
  logic [nts_pkg::IDX_W-1:0]    pick;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = (state_q == ST_FINISH) && out_free;

  // ring of cells, cell 0 is the head seen by the scan unit
  for (genvar i = 0; i < nts_pkg::DEPTH; i++) begin : g_cell
    nts_pkg::cell_ctl_t ctl;
    always_comb begin
      ctl.shift = (state_q == ST_SCAN);
      ctl.clr   = clr_all;
      ctl.wr    = wr_en && (wr_idx == nts_pkg::IDX_W'(i));
    end
    nts_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .nxt_stamp_i (cell_stamp[(i + 1) % nts_pkg::DEPTH]),
      .nxt_valid_i (cell_valid[(i + 1) % nts_pkg::DEPTH]),
      .wr_stamp_i  (key_q),
      .stamp_o     (cell_stamp[i]),
      .valid_o     (cell_valid[i])
    );
  end

  assign scan_ctl.start = accept;
  assign scan_ctl.step  = (state_q == ST_SCAN);
  assign scan_ctl.idx   = idx_q;

  nts_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .key_i        (key_q),
    .head_stamp_i (cell_stamp[0]),
    .head_valid_i (cell_valid[0]),
    .res_o        (scan_res)
  );

  // capacity of zero acts as one, above DEPTH it saturates
  always_comb begin
    cap_ext = nts_pkg::CMP_W'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = nts_pkg::CMP_W'(1);
    end else if (cap_ext > nts_pkg::CMP_W'(nts_pkg::DEPTH)) begin
      eff_cap = nts_pkg::CMP_W'(nts_pkg::DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
    full = nts_pkg::CMP_W'(count_q) >= eff_cap;
  end

  assign dist_lo = key_q - scan_res.lo_stamp;
  assign dist_hi = scan_res.hi_stamp - key_q;

  // final decision, applied in the last cycle of an item
  always_comb begin
    out_d   = '0;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_idx  = '0;
    clr_all = 1'b0;
    pick    = '0;
    case (kind_q)
      nts_pkg::KIND_INSERT: begin
        if (scan_res.ex_have) begin
          pick        = scan_res.ex_idx;
          out_d.found = 1'b1;
          out_d.exact = 1'b1;
        end else if (full && scan_res.min_have) begin
          pick          = scan_res.min_idx;
          wr_en         = finish;
          out_d.found   = 1'b1;
          out_d.evicted = 1'b1;
        end else if (scan_res.free_have) begin
          pick        = scan_res.free_idx;
          wr_en       = finish;
          out_d.found = 1'b1;
          count_d     = count_q + nts_pkg::CNT_W'(1);
        end
      end
      nts_pkg::KIND_LOOKUP: begin
        if (scan_res.ex_have) begin
          pick        = scan_res.ex_idx;
          out_d.found = 1'b1;
          out_d.exact = 1'b1;
        end else if (scan_res.lo_have && !scan_res.hi_have) begin
          pick        = scan_res.lo_idx;
          out_d.found = 1'b1;
        end else if (scan_res.hi_have && !scan_res.lo_have) begin
          pick        = scan_res.hi_idx;
          out_d.found = 1'b1;
        end else if (scan_res.lo_have) begin
          // lower neighbor wins only when strictly closer
          pick        = (dist_lo < dist_hi) ? scan_res.lo_idx : scan_res.hi_idx;
          out_d.found = 1'b1;
        end
      end
      nts_pkg::KIND_CLEAR: begin
        clr_all = finish;
        count_d = '0;
      end
      default: begin
      end
    endcase
    wr_idx     = pick;
    out_d.slot = nts_pkg::SLOT_W'(pick);
    out_d.fill = nts_pkg::FILL_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      cap_q       <= nts_pkg::CAP_W'(30);
      out_valid_q <= 1'b0;
      out_q       <= '0;
      key_q       <= '0;
      kind_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && !finish) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            key_q  <= in_item_i.stamp;
            kind_q <= in_item_i.kind;
            idx_q  <= '0;
            if (in_item_i.kind == nts_pkg::KIND_INSERT ||
                in_item_i.kind == nts_pkg::KIND_LOOKUP) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          idx_q <= idx_q + nts_pkg::IDX_W'(1);
          if (idx_q == nts_pkg::IDX_W'(nts_pkg::DEPTH - 1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_q       <= out_d;
            out_valid_q <= 1'b1;
            count_q     <= count_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[bench/tb_nearest_timestamp_frame_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_timestamp_frame_table_core
// Drives insert, lookup, clear and unused-kind items into the frame table
// under several capacity settings and idling patterns. Every result is checked,
// against fixed values for some rows of a short stimulus table that opens the
// run and against an in-bench model of the slot table for all the others.
// ----------------------------------------------------------------------------
module tb_nearest_timestamp_frame_table_core;

  localparam logic [1:0]                  KIND_UNUSED = 2'd3;
  localparam logic [nts_pkg::STAMP_W-1:0] STAMP_MAX   = {nts_pkg::STAMP_W{1'b1}};
  localparam nts_pkg::out_item_t          NO_SLOT     = '0;
  localparam int                          CYCLE_LIMIT = 400_000;
  localparam int                          SETTLE_CYCLES = 40;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [nts_pkg::CAP_W-1:0] cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  nts_pkg::in_item_t         in_item = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  nts_pkg::out_item_t        out_item;

  // table model state
  logic [nts_pkg::STAMP_W-1:0] tbl_stamp [nts_pkg::DEPTH];
  bit                          tbl_valid [nts_pkg::DEPTH];
  int unsigned                 tbl_count = 0;
  logic [nts_pkg::CAP_W-1:0]   cap_setting = 6'd30;

  nts_pkg::out_item_t          slot_reports_due[$];
  int                          mismatch_count = 0;
  int                          cycle_count = 0;
  int                          send_idle_pct = 0;
  int                          stall_pct = 0;
  int                          clear_pct = 3;
  logic [nts_pkg::STAMP_W-1:0] cluster_base = '0;
  logic                        hold_request = 1'b0;

  typedef struct {
    nts_pkg::in_item_t  item;
    bit                 known;
    nts_pkg::out_item_t want;
  } plan_row_t;

  plan_row_t opening_plan[$];

  nearest_timestamp_frame_table_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[nearest_timestamp_frame_table_core] ERROR");
      $finish;
    end
  end

  // Applies one item to the table model and returns the slot report it causes.
  function automatic nts_pkg::out_item_t apply_table_op(input nts_pkg::in_item_t it);
    nts_pkg::out_item_t          res;
    int                          i;
    int                          pick;
    bit                          have;
    int unsigned                 eff;
    int                          lo;
    int                          hi;
    bit                          have_lo;
    bit                          have_hi;
    logic [nts_pkg::STAMP_W-1:0] key;
    res  = '0;
    key  = it.stamp;
    have = 1'b0;
    pick = 0;
    case (it.kind)
      nts_pkg::KIND_INSERT: begin
        for (i = 0; i < nts_pkg::DEPTH; i++) begin
          if (!have && tbl_valid[i] && tbl_stamp[i] == key) begin
            have = 1'b1;
            pick = i;
          end
        end
        if (have) begin
          res.slot  = nts_pkg::SLOT_W'(pick);
          res.found = 1'b1;
          res.exact = 1'b1;
        end else begin
          eff = (cap_setting == 0) ? 1 :
                (cap_setting > nts_pkg::DEPTH) ? nts_pkg::DEPTH : cap_setting;
          if (tbl_count >= eff) begin
            for (i = 0; i < nts_pkg::DEPTH; i++) begin
              if (tbl_valid[i] && (!have || tbl_stamp[i] < tbl_stamp[pick])) begin
                pick = i;
                have = 1'b1;
              end
            end
            if (have) begin
              tbl_stamp[pick] = key;
              res.slot    = nts_pkg::SLOT_W'(pick);
              res.found   = 1'b1;
              res.evicted = 1'b1;
            end
          end
          if (!have) begin
            for (i = 0; i < nts_pkg::DEPTH; i++) begin
              if (!have && !tbl_valid[i]) begin
                have = 1'b1;
                tbl_valid[i] = 1'b1;
                tbl_stamp[i] = key;
                tbl_count++;
                res.slot  = nts_pkg::SLOT_W'(i);
                res.found = 1'b1;
              end
            end
          end
        end
      end
      nts_pkg::KIND_LOOKUP: begin
        lo = 0;
        hi = 0;
        have_lo = 1'b0;
        have_hi = 1'b0;
        for (i = 0; i < nts_pkg::DEPTH; i++) begin
          if (tbl_valid[i] && !have) begin
            if (tbl_stamp[i] == key) begin
              have = 1'b1;
              pick = i;
            end else if (tbl_stamp[i] < key) begin
              if (!have_lo || tbl_stamp[i] > tbl_stamp[lo]) begin
                lo = i;
                have_lo = 1'b1;
              end
            end else if (!have_hi || tbl_stamp[i] < tbl_stamp[hi]) begin
              hi = i;
              have_hi = 1'b1;
            end
          end
        end
        if (have) begin
          res.slot  = nts_pkg::SLOT_W'(pick);
          res.found = 1'b1;
          res.exact = 1'b1;
        end else if (have_lo || have_hi) begin
          res.found = 1'b1;
          // lower neighbor wins only when strictly closer
          if (!have_hi || (have_lo && (key - tbl_stamp[lo]) < (tbl_stamp[hi] - key))) begin
            res.slot = nts_pkg::SLOT_W'(lo);
          end else begin
            res.slot = nts_pkg::SLOT_W'(hi);
          end
        end
      end
      nts_pkg::KIND_CLEAR: begin
        for (i = 0; i < nts_pkg::DEPTH; i++) tbl_valid[i] = 1'b0;
        tbl_count = 0;
      end
      default: ;
    endcase
    res.fill = nts_pkg::FILL_W'(tbl_count);
    return res;
  endfunction

  function automatic void check_slot_report(input nts_pkg::out_item_t got);
    nts_pkg::out_item_t want;
    if (slot_reports_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected result %p", got);
      return;
    end
    want = slot_reports_due.pop_front();
    if (got.slot !== want.slot || got.found !== want.found || got.exact !== want.exact ||
        got.evicted !== want.evicted || got.fill !== want.fill) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch: expected slot=%0d found=%0b exact=%0b evicted=%0b fill=%0d",
                 want.slot, want.found, want.exact, want.evicted, want.fill);
        $display("          actual   slot=%0d found=%0b exact=%0b evicted=%0b fill=%0d",
                 got.slot, got.found, got.exact, got.evicted, got.fill);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_slot_report(out_item);
      out_stall <= hold_request || ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [nts_pkg::STAMP_W-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[nts_pkg::STAMP_W-1:0];
  endfunction

  function automatic nts_pkg::in_item_t random_item();
    nts_pkg::in_item_t           it;
    int                          r;
    int                          k;
    int                          i;
    logic [nts_pkg::STAMP_W-1:0] near;
    near = '0;
    r = $urandom_range(0, 99);
    it.stamp = cluster_base + nts_pkg::STAMP_W'($urandom_range(0, 127));
    if (r < clear_pct) begin
      it.kind = nts_pkg::KIND_CLEAR;
    end else if (r < clear_pct + 2) begin
      it.kind  = KIND_UNUSED;
      it.stamp = rand_stamp();
    end else if (r < 52) begin
      it.kind = nts_pkg::KIND_INSERT;
      if ($urandom_range(0, 4) == 0) it.stamp = rand_stamp();
    end else begin
      it.kind = nts_pkg::KIND_LOOKUP;
      r = $urandom_range(0, 9);
      if (r < 2) begin
        it.stamp = rand_stamp();
      end else if (r < 8 && tbl_count != 0) begin
        // aim close to a held stamp so exact hits and ties show up
        k = $urandom_range(0, tbl_count - 1);
        for (i = 0; i < nts_pkg::DEPTH; i++) begin
          if (tbl_valid[i]) begin
            if (k == 0) near = tbl_stamp[i];
            k--;
          end
        end
        it.stamp = near + nts_pkg::STAMP_W'($urandom_range(0, 6)) - nts_pkg::STAMP_W'(3);
      end
    end
    return it;
  endfunction

  task automatic offer_item(input nts_pkg::in_item_t it, input bit known,
                            input nts_pkg::out_item_t want);
    nts_pkg::out_item_t outcome;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    outcome = apply_table_op(it);
    slot_reports_due.insert(slot_reports_due.size(), known ? want : outcome);
  endtask

  task automatic run_random(input int count);
    int n;
    case ($urandom_range(0, 3))
      0:       cluster_base = '0;
      1:       cluster_base = STAMP_MAX - nts_pkg::STAMP_W'(100);
      default: cluster_base = rand_stamp();
    endcase
    for (n = 0; n < count; n++) offer_item(random_item(), 1'b0, NO_SLOT);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (slot_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [nts_pkg::CAP_W-1:0] value);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_setting = value;
  endtask

  function automatic void plan_row(input logic [1:0] kind,
                                   input logic [nts_pkg::STAMP_W-1:0] stamp,
                                   input bit known, input nts_pkg::out_item_t want);
    plan_row_t row;
    row.item.kind  = kind;
    row.item.stamp = stamp;
    row.known      = known;
    row.want       = want;
    opening_plan.insert(opening_plan.size(), row);
  endfunction

  initial begin
    // slot, found, exact, evicted, fill
    plan_row(nts_pkg::KIND_LOOKUP, 52'd5, 1'b1, {5'd0, 1'b0, 1'b0, 1'b0, 6'd0});  // empty
    plan_row(KIND_UNUSED, STAMP_MAX, 1'b1, {5'd0, 1'b0, 1'b0, 1'b0, 6'd0});
    plan_row(nts_pkg::KIND_INSERT, 52'd0, 1'b1, {5'd0, 1'b1, 1'b0, 1'b0, 6'd1});
    plan_row(nts_pkg::KIND_INSERT, STAMP_MAX, 1'b1, {5'd1, 1'b1, 1'b0, 1'b0, 6'd2});
    plan_row(nts_pkg::KIND_INSERT, 52'd100, 1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_INSERT, 52'd100, 1'b0, NO_SLOT);       // key already held
    plan_row(nts_pkg::KIND_LOOKUP, 52'd100, 1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_LOOKUP, 52'd50,  1'b0, NO_SLOT);       // tie goes high
    plan_row(nts_pkg::KIND_LOOKUP, 52'd49,  1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_INSERT, 52'd200, 1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_LOOKUP, 52'd150, 1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_LOOKUP, STAMP_MAX - 52'd1, 1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_LOOKUP, 52'h8_0000_0000_0000, 1'b0, NO_SLOT);
    plan_row(KIND_UNUSED, 52'd0, 1'b0, NO_SLOT);                  // fill unchanged
    plan_row(nts_pkg::KIND_CLEAR,  52'd77, 1'b1, {5'd0, 1'b0, 1'b0, 1'b0, 6'd0});
    plan_row(nts_pkg::KIND_LOOKUP, 52'd7,  1'b1, {5'd0, 1'b0, 1'b0, 1'b0, 6'd0});
    plan_row(nts_pkg::KIND_INSERT, 52'd20, 1'b1, {5'd0, 1'b1, 1'b0, 1'b0, 6'd1});
    plan_row(nts_pkg::KIND_INSERT, 52'd10, 1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_LOOKUP, 52'd5,  1'b0, NO_SLOT);        // below lowest
    plan_row(nts_pkg::KIND_LOOKUP, 52'd30, 1'b0, NO_SLOT);        // above highest
    plan_row(nts_pkg::KIND_LOOKUP, 52'd15, 1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_LOOKUP, 52'd0,  1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_LOOKUP, STAMP_MAX, 1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_INSERT, 52'h5_5555_5555_5555, 1'b0, NO_SLOT);
    plan_row(nts_pkg::KIND_INSERT, 52'hA_AAAA_AAAA_AAAA, 1'b0, NO_SLOT);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_plan[r]) offer_item(opening_plan[r].item, opening_plan[r].known,
                                         opening_plan[r].want);

    // capacity zero acts as one
    write_capacity(6'd0);
    clear_pct = 5;
    run_random(100);

    write_capacity(6'd32);
    send_idle_pct <= 53;
    clear_pct = 0;
    run_random(200);

    // above DEPTH saturates; long output hold-off fills the pipe
    write_capacity(6'd63);
    send_idle_pct <= 0;
    stall_pct     <= 53;
    run_random(80);
    fork
      begin
        hold_request <= 1'b1;
        repeat (300) @(posedge clk);
        hold_request <= 1'b0;
      end
      run_random(30);
    join
    run_random(60);

    // lowered below the current fill
    write_capacity(6'd3);
    send_idle_pct <= 28;
    stall_pct     <= 28;
    run_random(150);

    write_capacity(6'd1);
    send_idle_pct <= 0;
    stall_pct     <= 0;
    clear_pct = 3;
    run_random(100);

    write_capacity(nts_pkg::CAP_W'($urandom_range(1, 32)));
    send_idle_pct <= 28;
    stall_pct     <= 28;
    run_random(100);
    drain_results();
    run_random(100);

    quiesce();
    if (mismatch_count == 0) begin
      $display("[nearest_timestamp_frame_table_core] OK");
    end else begin
      $display("[nearest_timestamp_frame_table_core] ERROR");
    end
    $finish;
  end

endmodule
